// File: design/mcp_pkg.sv
// Shared types and constants of the MSB-first code packer.
// Depends on nothing; every module of the block uses it.
package mcp_pkg;

    // Fixed field widths of the channels and the register
    localparam int CODE_W    = 32;
    localparam int LEN_IN_W  = 6;
    localparam int CFG_W     = 16;
    localparam int BITS_W    = 19;
    localparam int TAKEN_W   = 16;
    localparam int BYTE_BITS = 8;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_CODE_BITS = 32;
    localparam int DEF_QUEUE_DEPTH   = 2;

    // Buffer size after reset, in bytes
    localparam logic [CFG_W-1:0] BUF_SIZE_RESET = 16'd4096;

    // Operation codes of an input beat
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CLOSE  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    // One result beat
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data_byte;
        logic [TAKEN_W-1:0] bytes_taken;
        logic               buffer_full;
        logic [BITS_W-1:0]  bits_left;
        logic               last;
    } mcp_result_t;

endpackage

// File: design/mcp_front.sv
// Front end: takes input beats, clamps the length, left-aligns the code
// and drops empty writes before they reach the command queue. Uses mcp_pkg.
module mcp_front #(
    parameter int MAX_CODE_BITS = mcp_pkg::DEF_MAX_CODE_BITS
) (
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          operation,
    input  logic [mcp_pkg::CODE_W-1:0]    code,
    input  logic [mcp_pkg::LEN_IN_W-1:0]  code_length,
    input  logic                          q_ready,
    output logic                          q_push,
    output logic                          q_close,
    output logic [$clog2(MAX_CODE_BITS+1)-1:0] q_len,
    output logic [MAX_CODE_BITS-1:0]      q_bits
);
    import mcp_pkg::*;

    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

    logic [LEN_W-1:0]    len_clamped;
    logic [LEN_IN_W-1:0] shift_amt;
    logic [CODE_W-1:0]   code_shifted;

    // Clamp overlong lengths to the widest code
    always_comb
    begin
        if (code_length > LEN_IN_W'(MAX_CODE_BITS))
            len_clamped = LEN_W'(MAX_CODE_BITS);
        else
            len_clamped = LEN_W'(code_length);
    end

    // Left-align the used code bits; the shift drops the unused high bits
    assign shift_amt    = LEN_IN_W'(MAX_CODE_BITS) - LEN_IN_W'(len_clamped);
    assign code_shifted = code << shift_amt;

    // Accept whenever the queue has room; an empty write is taken and dropped
    assign item_ready = q_ready;
    assign q_push     = item_valid && q_ready
                        && (operation == OP_CLOSE || len_clamped != '0);
    assign q_close    = (operation == OP_CLOSE);
    assign q_len      = len_clamped;
    assign q_bits     = code_shifted[MAX_CODE_BITS-1:0];

endmodule

// File: design/mcp_queue.sv
// Short command queue between the front end and the packing engine.
// Depends on mcp_pkg for the default depth.
module mcp_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = mcp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              push_ready,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: design/mcp_back.sv
// Packing engine: buffer state, byte assembly, tail hold, close sequence,
// buffer-size register and the result output register. Uses mcp_pkg.
module mcp_back #(
    parameter int MAX_CODE_BITS = mcp_pkg::DEF_MAX_CODE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mcp_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          head_valid,
    input  logic                          head_close,
    input  logic [$clog2(MAX_CODE_BITS+1)-1:0] head_len,
    input  logic [MAX_CODE_BITS-1:0]      head_bits,
    output logic                          pop,
    output logic                          result_valid,
    input  logic                          result_ready,
    output mcp_pkg::mcp_result_t          result
);
    import mcp_pkg::*;

    localparam int W     = MAX_CODE_BITS;
    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLOSE,
        S_STEP
    } state_t;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   cfg_reg, cfg_next;
    logic [BITS_W-1:0]  cons_reg, cons_next;
    logic [7:0]         pbyte_reg, pbyte_next;
    logic [2:0]         pfill_reg, pfill_next;
    logic [W-1:0]       held_bits_reg, held_bits_next;
    logic [LEN_W-1:0]   held_cnt_reg, held_cnt_next;
    logic [W-1:0]       sbits_reg, sbits_next;
    logic [LEN_W-1:0]   scnt_reg, scnt_next;
    logic               res_valid_reg, res_valid_next;
    mcp_result_t        res_reg, res_next;

    logic [BITS_W-1:0]  cap;
    logic [BITS_W-1:0]  left;
    logic [LEN_W-1:0]   avail;
    logic [3:0]         need;
    logic               absorb;
    logic [3:0]         take;
    logic [15:0]        merged;
    logic [BITS_W-1:0]  cons_after;
    logic [BITS_W-1:0]  left_after;
    logic [LEN_W-1:0]   scnt_after;
    logic [LEN_W-1:0]   avail_after;
    logic [W-1:0]       sbits_after;
    logic               out_free;
    logic               marker_last;
    logic               reject;

    // Build a result beat with the buffer status for a given fill
    function automatic mcp_result_t pack_result(
        input kind_t             k,
        input logic [7:0]        b,
        input logic [BITS_W-1:0] cons,
        input logic [BITS_W-1:0] capacity,
        input logic              lst
    );
        logic [BITS_W-1:0] lf;
        logic [BITS_W:0]   rnd;
        mcp_result_t       r;
        lf  = (capacity > cons) ? capacity - cons : '0;
        rnd = {1'b0, cons} + (BITS_W+1)'(7);
        r.kind        = k;
        r.data_byte   = b;
        r.bytes_taken = rnd[TAKEN_W+2:3];
        r.buffer_full = (lf == '0);
        r.bits_left   = lf;
        r.last        = lst;
        return r;
    endfunction

    // Free space and the bit count of this step
    assign cap    = {cfg_reg, 3'b000};
    assign left   = (cap > cons_reg) ? cap - cons_reg : '0;
    assign avail  = (left >= BITS_W'(scnt_reg)) ? scnt_reg : left[LEN_W-1:0];
    assign need   = 4'(BYTE_BITS) - {1'b0, pfill_reg};
    assign absorb = (avail < LEN_W'(need));
    assign take   = absorb ? avail[3:0] : need;

    // Shift the top bits of the stream into the partial byte
    assign merged      = {pbyte_reg, sbits_reg[W-1 -: 8]} << take;
    assign sbits_after = sbits_reg << take;
    assign scnt_after  = scnt_reg - LEN_W'(take);
    assign cons_after  = cons_reg + BITS_W'(take);
    assign left_after  = (cap > cons_after) ? cap - cons_after : '0;
    assign avail_after = (left_after >= BITS_W'(scnt_after)) ? scnt_after
                                                             : left_after[LEN_W-1:0];

    assign out_free    = !res_valid_reg || result_ready;
    assign marker_last = !(held_cnt_reg >= LEN_W'(BYTE_BITS) && cap >= BITS_W'(BYTE_BITS));
    assign reject      = !head_close && held_cnt_reg != '0 && left < BITS_W'(head_len);

    // Sequence commands: load, reject, close, and at most one byte per step
    always_comb
    begin
        state_next     = state_reg;
        cfg_next       = cfg_wr_en ? cfg_wr_data : cfg_reg;
        cons_next      = cons_reg;
        pbyte_next     = pbyte_reg;
        pfill_next     = pfill_reg;
        held_bits_next = held_bits_reg;
        held_cnt_next  = held_cnt_reg;
        sbits_next     = sbits_reg;
        scnt_next      = scnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;
        pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_close)
                    begin
                        pop        = 1'b1;
                        state_next = S_CLOSE;
                    end
                    else if (reject)
                    begin
                        if (out_free)
                        begin
                            pop            = 1'b1;
                            res_valid_next = 1'b1;
                            res_next       = pack_result(KIND_REJECT, 8'd0, cons_reg,
                                                         cap, 1'b1);
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        sbits_next = head_bits;
                        scnt_next  = head_len;
                        state_next = S_STEP;
                    end
                end
            end

            S_CLOSE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    if (pfill_reg != '0)
                    begin
                        // Emit the padded last byte first
                        res_next   = pack_result(KIND_DATA, pbyte_reg << need, cons_reg,
                                                 cap, 1'b0);
                        pbyte_next = '0;
                        pfill_next = '0;
                    end
                    else
                    begin
                        // Mark the close, open a new buffer and feed it the tail
                        res_next      = pack_result(KIND_CLOSE, 8'd0, cons_reg, cap,
                                                    marker_last);
                        cons_next     = '0;
                        sbits_next    = held_bits_reg;
                        scnt_next     = held_cnt_reg;
                        held_cnt_next = '0;
                        state_next    = (held_cnt_reg != '0) ? S_STEP : S_IDLE;
                    end
                end
            end

            S_STEP:
            begin
                if (absorb)
                begin
                    // Too few bits for a byte: absorb them and finish
                    pbyte_next = merged[15:8];
                    pfill_next = pfill_reg + 3'(take);
                    cons_next  = cons_after;
                    sbits_next = sbits_after;
                    scnt_next  = scnt_after;
                    if (scnt_after != '0)
                    begin
                        held_bits_next = sbits_after;
                        held_cnt_next  = scnt_after;
                    end
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    // Complete a byte and emit it
                    res_valid_next = 1'b1;
                    res_next       = pack_result(KIND_DATA, merged[15:8], cons_after, cap,
                                                 avail_after < LEN_W'(BYTE_BITS));
                    pbyte_next     = '0;
                    pfill_next     = '0;
                    cons_next      = cons_after;
                    sbits_next     = sbits_after;
                    scnt_next      = scnt_after;
                    if (avail_after == '0)
                    begin
                        if (scnt_after != '0)
                        begin
                            held_bits_next = sbits_after;
                            held_cnt_next  = scnt_after;
                        end
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= BUF_SIZE_RESET;
            cons_reg      <= '0;
            pbyte_reg     <= '0;
            pfill_reg     <= '0;
            held_bits_reg <= '0;
            held_cnt_reg  <= '0;
            sbits_reg     <= '0;
            scnt_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            cons_reg      <= cons_next;
            pbyte_reg     <= pbyte_next;
            pfill_reg     <= pfill_next;
            held_bits_reg <= held_bits_next;
            held_cnt_reg  <= held_cnt_next;
            sbits_reg     <= sbits_next;
            scnt_reg      <= scnt_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // The tail never holds more than one code
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg <= LEN_W'(W))
        else $error("held tail exceeds one code");

    // Appending never runs past the buffer capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cons_reg != $past(cons_reg) && cons_reg != '0) |-> cons_reg <= cap)
        else $error("buffer fill passed capacity");

    // The close marker starts an empty buffer
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLOSE && out_free && pfill_reg == '0)
        |=> (cons_reg == '0 && pfill_reg == '0))
        else $error("close did not clear the buffer");

    // A reject is always the only result of its beat and carries the last flag
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.kind == KIND_REJECT) |-> res_reg.last)
        else $error("reject without last");

endmodule

// File: design/msb_first_code_packer.sv
// Top level of the MSB-first code packer: front end, command queue, engine.
// Depends on mcp_pkg, mcp_front, mcp_queue and mcp_back.
//
//   Channel   Signals                                   Beat moves when
//   item      item_valid/item_ready, operation, code,   item_valid & item_ready
//             code_length
//   result    result_valid/result_ready, kind,          result_valid & result_ready
//             data_byte, bytes_taken, buffer_full,
//             bits_left, last
//   config    cfg_wr_en, cfg_wr_data                    cfg_wr_en
//
// A write leaves the queue in the idle state, then the engine takes a step per
// completed byte, plus an absorb step when bits remain after the last completed
// byte. A close leaves the queue, then the engine emits the padded byte if bits
// are pending, the marker, then any held tail in the same way as a write.
// The engine emits at most one result per cycle; that sets the rate.
// Reset clears the buffer and tail and sets the buffer size to 4096 bytes.
// A stalled result channel holds the engine at its next result; the queue keeps taking items
// until it is full.
module msb_first_code_packer #(
    parameter int MAX_CODE_BITS = mcp_pkg::DEF_MAX_CODE_BITS,
    parameter int QUEUE_DEPTH   = mcp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mcp_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          operation,
    input  logic [mcp_pkg::CODE_W-1:0]    code,
    input  logic [mcp_pkg::LEN_IN_W-1:0]  code_length,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [1:0]                    kind,
    output logic [7:0]                    data_byte,
    output logic [mcp_pkg::TAKEN_W-1:0]   bytes_taken,
    output logic                          buffer_full,
    output logic [mcp_pkg::BITS_W-1:0]    bits_left,
    output logic                          last
);
    import mcp_pkg::*;

    localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
    localparam int DATA_W = 1 + LEN_W + MAX_CODE_BITS;

    logic                     q_ready;
    logic                     q_push;
    logic                     q_close;
    logic [LEN_W-1:0]         q_len;
    logic [MAX_CODE_BITS-1:0] q_bits;
    logic                     head_valid;
    logic [DATA_W-1:0]        head_data;
    logic                     pop;
    mcp_result_t              res;

    mcp_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .operation   (operation),
        .code        (code),
        .code_length (code_length),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_close     (q_close),
        .q_len       (q_len),
        .q_bits      (q_bits)
    );

    mcp_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  ({q_close, q_len, q_bits}),
        .push_ready (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    mcp_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .head_valid   (head_valid),
        .head_close   (head_data[DATA_W-1]),
        .head_len     (head_data[DATA_W-2 -: LEN_W]),
        .head_bits    (head_data[MAX_CODE_BITS-1:0]),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (res)
    );

    // Split the result beat onto its ports
    assign kind        = res.kind;
    assign data_byte   = res.data_byte;
    assign bytes_taken = res.bytes_taken;
    assign buffer_full = res.buffer_full;
    assign bits_left   = res.bits_left;
    assign last        = res.last;

endmodule
